FILE: rtl/qtm_pkg.sv
// ---------------------------------------------------------------------------
// qtm_pkg
// shared types and constants for the quaternion/scale/position to model
// matrix block
// ---------------------------------------------------------------------------
package qtm_pkg;

  localparam int QTM_QW  = 16;   // quaternion component width, Q2.14
  localparam int QTM_SW  = 32;   // scale, position and matrix entry width, Q16.16
  localparam int QTM_PW  = 32;   // width of one quaternion component product
  localparam int QTM_BW  = 34;   // basis entry width, Q.28
  localparam int QTM_MW  = 33;   // basis magnitude width
  localparam int QTM_HW  = 16;   // half of a scale magnitude
  localparam int QTM_PPW = 49;   // partial product width
  localparam int QTM_AW  = 64;   // accumulated product width
  localparam int QTM_RW  = 36;   // rounded magnitude width

  localparam logic signed [QTM_BW-1:0] ONE_Q28    = QTM_BW'(64'd1 << 28);
  localparam logic [QTM_AW-1:0]        ROUND_Q28  = QTM_AW'(64'd1 << 27);
  localparam logic [QTM_SW-1:0]        SCALE_PASS = QTM_SW'(64'd1 << 28);
  localparam logic signed [QTM_SW-1:0] ONE_Q16    = 32'sd65536;
  localparam logic signed [QTM_SW-1:0] SAT_POS    = 32'sh7FFF_FFFF;
  localparam logic signed [QTM_SW-1:0] SAT_NEG    = 32'sh8000_0000;
  localparam logic [QTM_RW-1:0]        MAG_POS_MAX = QTM_RW'(64'h7FFF_FFFF);
  localparam logic [QTM_RW-1:0]        MAG_NEG_MAX = QTM_RW'(64'h8000_0000);

  localparam logic [1:0] ROW_X    = 2'd0;
  localparam logic [1:0] ROW_Y    = 2'd1;
  localparam logic [1:0] ROW_Z    = 2'd2;
  localparam logic [1:0] LAST_ROW = 2'd3;

  typedef logic signed [QTM_BW-1:0] bas_ent_t;

  typedef struct packed {
    logic signed [QTM_QW-1:0] quat_x;
    logic signed [QTM_QW-1:0] quat_y;
    logic signed [QTM_QW-1:0] quat_z;
    logic signed [QTM_QW-1:0] quat_w;
    logic signed [QTM_SW-1:0] scale_x;
    logic signed [QTM_SW-1:0] scale_y;
    logic signed [QTM_SW-1:0] scale_z;
    logic signed [QTM_SW-1:0] pos_x;
    logic signed [QTM_SW-1:0] pos_y;
    logic signed [QTM_SW-1:0] pos_z;
  } qtm_in_t;

  typedef struct packed {
    logic [1:0]               row_index;
    logic signed [QTM_SW-1:0] elem_0;
    logic signed [QTM_SW-1:0] elem_1;
    logic signed [QTM_SW-1:0] elem_2;
    logic signed [QTM_SW-1:0] elem_3;
    logic                     last_row;
  } qtm_out_t;

  // full basis of one item with its scale and position
  typedef struct packed {
    bas_ent_t [2:0][2:0]       m;      // m[row][col]
    logic [2:0][QTM_SW-1:0]    scale;  // per row
    logic [2:0][QTM_SW-1:0]    pos;
  } qtm_bas_t;

  // one row on its way to the scaling pipeline
  typedef struct packed {
    logic [1:0]             row_index;
    logic                   last_row;
    bas_ent_t [2:0]         bas;
    logic [QTM_SW-1:0]      scale;
  } qtm_row_t;

endpackage

FILE: rtl/qtm_basis.sv
// ---------------------------------------------------------------------------
// qtm_basis
// two-stage pipeline: component products, then doubled-product basis sums
// ---------------------------------------------------------------------------
module qtm_basis import qtm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  qtm_in_t  in_data,
  output logic     bas_valid,
  input  logic     bas_ready,
  output qtm_bas_t bas
);

  logic signed [QTM_PW-1:0] p_xx_r, p_xy_r, p_xz_r, p_yy_r, p_yz_r, p_zz_r;
  logic signed [QTM_PW-1:0] p_wx_r, p_wy_r, p_wz_r;
  qtm_in_t  item1_r;
  logic     v1_r, v2_r;
  qtm_bas_t bas_r;
  logic     rdy1, rdy2;

  function automatic bas_ent_t dbl(input logic signed [QTM_PW-1:0] p);
    return {p[QTM_PW-1], p, 1'b0};
  endfunction

  assign rdy2     = !v2_r || bas_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  // stage 1: products of the components
  always_ff @(posedge clk) begin
    if (rdy1) begin
      item1_r <= in_data;
      p_xx_r  <= QTM_PW'(in_data.quat_x) * QTM_PW'(in_data.quat_x);
      p_xy_r  <= QTM_PW'(in_data.quat_x) * QTM_PW'(in_data.quat_y);
      p_xz_r  <= QTM_PW'(in_data.quat_x) * QTM_PW'(in_data.quat_z);
      p_yy_r  <= QTM_PW'(in_data.quat_y) * QTM_PW'(in_data.quat_y);
      p_yz_r  <= QTM_PW'(in_data.quat_y) * QTM_PW'(in_data.quat_z);
      p_zz_r  <= QTM_PW'(in_data.quat_z) * QTM_PW'(in_data.quat_z);
      p_wx_r  <= QTM_PW'(in_data.quat_w) * QTM_PW'(in_data.quat_x);
      p_wy_r  <= QTM_PW'(in_data.quat_w) * QTM_PW'(in_data.quat_y);
      p_wz_r  <= QTM_PW'(in_data.quat_w) * QTM_PW'(in_data.quat_z);
    end
  end

  // stage 2: basis entries in Q.28
  always_ff @(posedge clk) begin
    if (rdy2) begin
      bas_r.m[0][0] <= ONE_Q28 - (dbl(p_yy_r) + dbl(p_zz_r));
      bas_r.m[0][1] <= dbl(p_xy_r) + dbl(p_wz_r);
      bas_r.m[0][2] <= dbl(p_xz_r) - dbl(p_wy_r);
      bas_r.m[1][0] <= dbl(p_xy_r) - dbl(p_wz_r);
      bas_r.m[1][1] <= ONE_Q28 - (dbl(p_xx_r) + dbl(p_zz_r));
      bas_r.m[1][2] <= dbl(p_yz_r) + dbl(p_wx_r);
      bas_r.m[2][0] <= dbl(p_xz_r) + dbl(p_wy_r);
      bas_r.m[2][1] <= dbl(p_yz_r) - dbl(p_wx_r);
      bas_r.m[2][2] <= ONE_Q28 - (dbl(p_xx_r) + dbl(p_yy_r));
      bas_r.scale[0] <= item1_r.scale_x;
      bas_r.scale[1] <= item1_r.scale_y;
      bas_r.scale[2] <= item1_r.scale_z;
      bas_r.pos[0]   <= item1_r.pos_x;
      bas_r.pos[1]   <= item1_r.pos_y;
      bas_r.pos[2]   <= item1_r.pos_z;
    end
  end

  assign bas_valid = v2_r;
  assign bas       = bas_r;

endmodule

FILE: rtl/qtm_rowgen.sv
// ---------------------------------------------------------------------------
// qtm_rowgen
// holds one item and issues its four rows, one per cycle while row_ready is high
// ---------------------------------------------------------------------------
module qtm_rowgen import qtm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     bas_valid,
  output logic     bas_ready,
  input  qtm_bas_t bas,
  output logic     row_valid,
  input  logic     row_ready,
  output qtm_row_t row
);

  qtm_bas_t   item_r;
  logic       held_r;
  logic [1:0] cnt_r;
  logic       last, fire, done;

  assign last      = (cnt_r == LAST_ROW);
  assign row_valid = held_r;
  assign fire      = held_r && row_ready;
  assign done      = fire && last;
  assign bas_ready = !held_r || done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      cnt_r  <= ROW_X;
    end else if (bas_valid && bas_ready) begin
      held_r <= 1'b1;
      cnt_r  <= ROW_X;
    end else if (fire) begin
      held_r <= !last;
      cnt_r  <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (bas_valid && bas_ready) item_r <= bas;
  end

  // position row goes through the scaler as pos times 1.0 in Q.28
  always_comb begin
    row.row_index = cnt_r;
    row.last_row  = last;
    case (cnt_r)
      ROW_X: begin
        row.bas   = item_r.m[0];
        row.scale = item_r.scale[0];
      end
      ROW_Y: begin
        row.bas   = item_r.m[1];
        row.scale = item_r.scale[1];
      end
      ROW_Z: begin
        row.bas   = item_r.m[2];
        row.scale = item_r.scale[2];
      end
      default: begin
        for (int c = 0; c < 3; c++)
          row.bas[c] = {{(QTM_BW-QTM_SW){item_r.pos[c][QTM_SW-1]}}, item_r.pos[c]};
        row.scale = SCALE_PASS;
      end
    endcase
  end

endmodule

FILE: rtl/qtm_scale.sv
// ---------------------------------------------------------------------------
// qtm_scale
// four-stage row pipeline: magnitudes, split products, round, saturate
// ---------------------------------------------------------------------------
module qtm_scale import qtm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     row_valid,
  output logic     row_ready,
  input  qtm_row_t row,
  output logic     out_valid,
  input  logic     out_ready,
  output qtm_out_t out_data
);

  logic [3:0] v_r;
  logic [3:0] rdy;

  // per stage side info
  logic [1:0] idx1_r, idx2_r, idx3_r;
  logic       lst1_r, lst2_r, lst3_r;
  logic [2:0] neg1_r, neg2_r, neg3_r;

  logic [2:0][QTM_MW-1:0]  mb1_r;
  logic [QTM_SW-1:0]       ms1_r;
  logic [2:0][QTM_PPW-1:0] plo2_r, phi2_r;
  logic [2:0][QTM_RW-1:0]  mag3_r;
  qtm_out_t                out_r;

  logic [2:0][QTM_BW-1:0]  nb;
  logic [QTM_SW-1:0]       ns;
  logic [2:0][QTM_AW-1:0]  sum;
  logic [2:0][QTM_SW-1:0]  sat;

  assign rdy[3] = !v_r[3] || out_ready;
  assign rdy[2] = !v_r[2] || rdy[3];
  assign rdy[1] = !v_r[1] || rdy[2];
  assign rdy[0] = !v_r[0] || rdy[1];
  assign row_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= row_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
    end
  end

  always_comb begin
    ns = QTM_SW'(-row.scale);
    for (int c = 0; c < 3; c++) begin
      nb[c]  = QTM_BW'(-row.bas[c]);
      sum[c] = QTM_AW'({phi2_r[c], {QTM_HW{1'b0}}}) + QTM_AW'(plo2_r[c]) + ROUND_Q28;
      if (neg3_r[c]) begin
        sat[c] = (mag3_r[c] >= MAG_NEG_MAX) ? SAT_NEG : QTM_SW'(-mag3_r[c]);
      end else begin
        sat[c] = (mag3_r[c] > MAG_POS_MAX) ? SAT_POS : mag3_r[c][QTM_SW-1:0];
      end
    end
  end

  // stage 1: sign and magnitude
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      idx1_r <= row.row_index;
      lst1_r <= row.last_row;
      ms1_r  <= row.scale[QTM_SW-1] ? ns : row.scale;
      for (int c = 0; c < 3; c++) begin
        mb1_r[c]  <= row.bas[c][QTM_BW-1] ? nb[c][QTM_MW-1:0] : row.bas[c][QTM_MW-1:0];
        neg1_r[c] <= row.bas[c][QTM_BW-1] ^ row.scale[QTM_SW-1];
      end
    end
  end

  // stage 2: magnitude times scale halves
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      idx2_r <= idx1_r;
      lst2_r <= lst1_r;
      neg2_r <= neg1_r;
      for (int c = 0; c < 3; c++) begin
        plo2_r[c] <= QTM_PPW'(mb1_r[c]) * QTM_PPW'(ms1_r[QTM_HW-1:0]);
        phi2_r[c] <= QTM_PPW'(mb1_r[c]) * QTM_PPW'(ms1_r[QTM_SW-1:QTM_HW]);
      end
    end
  end

  // stage 3: join halves, round to nearest, Q.44 to Q16.16
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      idx3_r <= idx2_r;
      lst3_r <= lst2_r;
      neg3_r <= neg2_r;
      for (int c = 0; c < 3; c++)
        mag3_r[c] <= sum[c][QTM_AW-1:28];
    end
  end

  // stage 4: saturate and apply sign into the output word
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      out_r.row_index <= idx3_r;
      out_r.last_row  <= lst3_r;
      out_r.elem_0    <= sat[0];
      out_r.elem_1    <= sat[1];
      out_r.elem_2    <= sat[2];
      out_r.elem_3    <= lst3_r ? ONE_Q16 : '0;
    end
  end

  assign out_valid = v_r[3];
  assign out_data  = out_r;

endmodule

FILE: rtl/quat_trs_model_matrix.sv
// ---------------------------------------------------------------------------
// quat_trs_model_matrix
// rotation quaternion, scale and position to a 4x4 model matrix, one row
// per output word
// ---------------------------------------------------------------------------
// path: an input word passes the two basis stages and is held in the row
//   sequencer, then each of its rows passes the four scaling stages in order
// flow: the row sequencer puts the four rows of an item onto the single
//   result channel and takes the next item only as the last row leaves
// reset: synchronous, active low; clears all valid bits and the row counter,
//   data registers are not reset
module quat_trs_model_matrix import qtm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  qtm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output qtm_out_t out_data
);

  // basis pipeline to row sequencer
  logic     bas_valid, bas_ready;
  qtm_bas_t bas;

  // row sequencer to scaling pipeline
  logic     row_valid, row_ready;
  qtm_row_t row;

  // products and basis sums, two stages
  qtm_basis u_basis (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .bas_valid (bas_valid),
    .bas_ready (bas_ready),
    .bas       (bas)
  );

  // holds one item while its four rows go out; takes the next item
  // in the same cycle the last row leaves
  qtm_rowgen u_rowgen (
    .clk       (clk),
    .rst_n     (rst_n),
    .bas_valid (bas_valid),
    .bas_ready (bas_ready),
    .bas       (bas),
    .row_valid (row_valid),
    .row_ready (row_ready),
    .row       (row)
  );

  // scale multiply, round and saturate, four stages with output register
  qtm_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_valid (row_valid),
    .row_ready (row_ready),
    .row       (row),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // expected row of the next output word, for the ordering check
  logic [1:0] exp_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_row_r <= ROW_X;
    end else if (out_valid && out_ready) begin
      exp_row_r <= out_data.row_index + 2'd1;
    end
  end

  // rows come out in order with none lost or repeated
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.row_index == exp_row_r))
    else $error("output row out of order");

  // last flag marks exactly the position row
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_row == (out_data.row_index == LAST_ROW)))
    else $error("last_row does not match row_index");

  // fourth entry is 1.0 on the position row and 0 elsewhere
  a_elem3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.elem_3 == (out_data.last_row ? ONE_Q16 : 32'sd0)))
    else $error("elem_3 wrong for row");

  // a new item enters the sequencer only when it is empty or on its last row
  a_seq_take: assert property (@(posedge clk) disable iff (!rst_n)
    (bas_valid && bas_ready && row_valid) |-> (row_ready && row.last_row))
    else $error("item taken while rows pending");

endmodule

FILE: dv/quat_trs_model_matrix_tb.sv
// ---------------------------------------------------------------------------
// quat_trs_model_matrix_tb
// self-checking bench for the quaternion/scale/position to model matrix block:
// a short directed table, then random words, each turned into four expected
// matrix rows by a local fixed-point model and compared field by field
// ---------------------------------------------------------------------------
module quat_trs_model_matrix_tb import qtm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_HALF    = 10;
  localparam int          RESET_CYC   = 7;
  localparam int          RAND_WORDS  = 280;
  localparam int          CYCLE_LIMIT = 400_000;
  localparam int          DRAIN_CYC   = 24;       // wait for stray rows after the last owed one
  localparam int          HOLD_CYC    = 200;      // one long receiver hold-off
  localparam int          HOLD_AFTER  = 40;       // rows seen before that hold-off
  localparam int          MAX_PRINTS  = 30;
  localparam longint      UNIT_Q28    = longint'(1) << 28;

  // the four rows of one matrix, row 0 in [0]
  typedef qtm_out_t [3:0] matrix_t;

  // one row of the directed table; rows marked typed carry their answer
  typedef struct {
    qtm_in_t word;
    bit      typed;
    matrix_t rows;
  } dir_entry_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  qtm_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  qtm_out_t out_data;

  qtm_out_t   pending_rows[$];   // matrix rows still owed by the block
  dir_entry_t dir_tab[$];
  int         mismatches = 0;
  int         rows_done  = 0;
  int         cycles     = 0;

  quat_trs_model_matrix dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows outstanding", cycles,
               pending_rows.size());
      $display("quat_trs_model_matrix test failed");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // ------------------------------------------------------------------------
  // fixed-point model
  // ------------------------------------------------------------------------

  // basis entry (Q.28) times scale (Q16.16) down to Q16.16:
  // exact magnitude product, round half away from zero, then saturate
  function automatic logic signed [QTM_SW-1:0] round_sat_q16(longint basis,
                                                             longint scl);
    bit          neg;
    logic [63:0] mb, ms, prod, mag, twos;
    neg  = (basis < 0) != (scl < 0);
    mb   = basis < 0 ? -basis : basis;
    ms   = scl < 0 ? -scl : scl;
    prod = mb * ms;                          // at most 2^63, no wrap
    mag  = (prod + (64'd1 << 27)) >> 28;
    if (neg) begin
      if (mag >= 64'h8000_0000)
        return SAT_NEG;
      twos = 64'd0 - mag;
      return twos[QTM_SW-1:0];
    end
    if (mag > 64'h7FFF_FFFF)
      return SAT_POS;
    return mag[QTM_SW-1:0];
  endfunction

  // rotation basis from doubled products, quaternion taken as is (no
  // normalizing), rows scaled per axis, position row passed straight through
  function automatic matrix_t compose_matrix(qtm_in_t w);
    longint  qx, qy, qz, qw, sx, sy, sz;
    longint  xx, xy, xz, yy, yz, zz, wx, wy, wz;
    matrix_t m;
    qx = $signed(w.quat_x);
    qy = $signed(w.quat_y);
    qz = $signed(w.quat_z);
    qw = $signed(w.quat_w);
    sx = $signed(w.scale_x);
    sy = $signed(w.scale_y);
    sz = $signed(w.scale_z);
    xx = qx * (2 * qx);
    xy = qx * (2 * qy);
    xz = qx * (2 * qz);
    yy = qy * (2 * qy);
    yz = qy * (2 * qz);
    zz = qz * (2 * qz);
    wx = qw * (2 * qx);
    wy = qw * (2 * qy);
    wz = qw * (2 * qz);
    m[0] = '{row_index: ROW_X,
             elem_0: round_sat_q16(UNIT_Q28 - (yy + zz), sx),
             elem_1: round_sat_q16(xy + wz, sx),
             elem_2: round_sat_q16(xz - wy, sx),
             elem_3: '0, last_row: 1'b0};
    m[1] = '{row_index: ROW_Y,
             elem_0: round_sat_q16(xy - wz, sy),
             elem_1: round_sat_q16(UNIT_Q28 - (xx + zz), sy),
             elem_2: round_sat_q16(yz + wx, sy),
             elem_3: '0, last_row: 1'b0};
    m[2] = '{row_index: ROW_Z,
             elem_0: round_sat_q16(xz + wy, sz),
             elem_1: round_sat_q16(yz - wx, sz),
             elem_2: round_sat_q16(UNIT_Q28 - (xx + yy), sz),
             elem_3: '0, last_row: 1'b0};
    m[3] = '{row_index: LAST_ROW, elem_0: w.pos_x, elem_1: w.pos_y,
             elem_2: w.pos_z, elem_3: ONE_Q16, last_row: 1'b1};
    return m;
  endfunction

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  function automatic qtm_in_t make_word(shortint qx, shortint qy, shortint qz,
                                        shortint qw, int sx, int sy, int sz,
                                        int px, int py, int pz);
    return '{quat_x: qx, quat_y: qy, quat_z: qz, quat_w: qw,
             scale_x: sx, scale_y: sy, scale_z: sz,
             pos_x: px, pos_y: py, pos_z: pz};
  endfunction

  // rotation-free matrix (identity or zero quaternion): d on the diagonal
  // when all three scales equal d, position row as given
  function automatic matrix_t diag_matrix(logic signed [QTM_SW-1:0] d,
                                          qtm_in_t w);
    matrix_t m;
    m[0] = '{row_index: ROW_X, elem_0: d, elem_1: '0, elem_2: '0,
             elem_3: '0, last_row: 1'b0};
    m[1] = '{row_index: ROW_Y, elem_0: '0, elem_1: d, elem_2: '0,
             elem_3: '0, last_row: 1'b0};
    m[2] = '{row_index: ROW_Z, elem_0: '0, elem_1: '0, elem_2: d,
             elem_3: '0, last_row: 1'b0};
    m[3] = '{row_index: LAST_ROW, elem_0: w.pos_x, elem_1: w.pos_y,
             elem_2: w.pos_z, elem_3: ONE_Q16, last_row: 1'b1};
    return m;
  endfunction

  task automatic add_dir(qtm_in_t w, bit typed, logic signed [QTM_SW-1:0] d);
    dir_entry_t e;
    e.word  = w;
    e.typed = typed;
    e.rows  = typed ? diag_matrix(d, w) : compose_matrix(w);
    dir_tab.push_back(e);
  endtask

  // idle run length: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [QTM_QW-1:0] rand_quat_comp();
    logic signed [QTM_QW-1:0] q;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       q = 16'sh8000;
          1:       q = 16'sh7FFF;
          2:       q = '0;
          3:       q = 16'sd16384;
          default: q = -16'sd16384;
        endcase
      end
      1, 2, 3: q = 16'(int'($urandom_range(0, 32768)) - 16384);  // within +-1.0
      default: q = 16'($urandom);
    endcase
    return q;
  endfunction

  // Q16.16 value; narrow keeps most of them within +-4.0
  function automatic logic signed [QTM_SW-1:0] rand_fix(bit narrow);
    logic signed [QTM_SW-1:0] v;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = SAT_NEG;
          1:       v = SAT_POS;
          2:       v = '0;
          3:       v = ONE_Q16;
          default: v = -ONE_Q16;
        endcase
      end
      1, 2, 3: v = narrow ? 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18))
                          : 32'($urandom);
      default: v = 32'($urandom);
    endcase
    return v;
  endfunction

  // offer one word, hold it until taken, then book its four rows
  task automatic send_word(qtm_in_t w, matrix_t rows, bit gap_free);
    int unsigned gap;
    gap = gap_free ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    for (int r = 0; r < 4; r++)
      pending_rows.push_back(rows[r]);
  endtask

  // ------------------------------------------------------------------------
  // result side: ready pattern and row checker
  // ------------------------------------------------------------------------

  // ready toggles in segments, some of them with no stalls at all; once,
  // after a few matrices, the receiver holds off long enough for the block
  // to fill and push back on the sender
  initial begin : rx_ready
    int unsigned seg, stall;
    bit          smooth;
    bit          held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      seg    = $urandom_range(16, 64);
      smooth = ($urandom_range(0, 3) == 0);
      repeat (seg) begin
        if (!held && rows_done >= HOLD_AFTER) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYC) @(posedge clk);
          held = 1'b1;
        end
        stall = smooth ? 0 : idle_len();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // each row taken is matched against the oldest one owed
  always @(posedge clk) begin : row_check
    qtm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      rows_done <= rows_done + 1;
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("row %0d arrived with nothing pending",
                                  out_data.row_index));
      end else begin
        want = pending_rows.pop_front();
        if (out_data.row_index !== want.row_index)
          report_mismatch($sformatf("row_index got %0d want %0d",
                                    out_data.row_index, want.row_index));
        if (out_data.elem_0 !== want.elem_0)
          report_mismatch($sformatf("row %0d elem_0 got %0d want %0d",
                                    want.row_index, out_data.elem_0, want.elem_0));
        if (out_data.elem_1 !== want.elem_1)
          report_mismatch($sformatf("row %0d elem_1 got %0d want %0d",
                                    want.row_index, out_data.elem_1, want.elem_1));
        if (out_data.elem_2 !== want.elem_2)
          report_mismatch($sformatf("row %0d elem_2 got %0d want %0d",
                                    want.row_index, out_data.elem_2, want.elem_2));
        if (out_data.elem_3 !== want.elem_3)
          report_mismatch($sformatf("row %0d elem_3 got %0d want %0d",
                                    want.row_index, out_data.elem_3, want.elem_3));
        if (out_data.last_row !== want.last_row)
          report_mismatch($sformatf("row %0d last_row got %0b want %0b",
                                    want.row_index, out_data.last_row,
                                    want.last_row));
      end
    end
  end

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin : main_seq
    qtm_in_t w;
    bit      gap_free;

    // directed table; rotation-free words carry a typed diagonal answer
    // identity quaternion, unit scale
    add_dir(make_word(0, 0, 0, 16384, 65536, 65536, 65536, 0, 0, 0), 1'b1, 65536);
    // zero scale flattens everything; position extremes pass through
    add_dir(make_word(0, 0, 0, 16384, 0, 0, 0,
                      32'sh7FFF_FFFF, 32'sh8000_0000, 0), 1'b1, 0);
    // largest scale stays exact on the diagonal
    add_dir(make_word(0, 0, 0, 16384, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                      32'sh7FFF_FFFF, -1, 1, 65536), 1'b1, SAT_POS);
    // most negative scale lands exactly on the negative limit
    add_dir(make_word(0, 0, 0, 16384, 32'sh8000_0000, 32'sh8000_0000,
                      32'sh8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA,
                      32'sh0F0F_F0F0), 1'b1, SAT_NEG);
    // negated identity quaternion gives the same rotation
    add_dir(make_word(0, 0, 0, -16384, 65536, 65536, 65536, 7, -7, 0), 1'b1, 65536);
    // zero quaternion: not normalized, basis falls back to identity
    add_dir(make_word(0, 0, 0, 0, 65536, 65536, 65536, 0, 0, 0), 1'b1, 65536);
    // quaternion extremes, far outside unit length, saturating both ways
    add_dir(make_word(-32768, -32768, -32768, -32768, 32'sh7FFF_FFFF,
                      32'sh8000_0000, 65536, 1, 2, 3), 1'b0, 0);
    add_dir(make_word(32767, 32767, 32767, 32767, 32'sh8000_0000,
                      32'sh7FFF_FFFF, -65536, -1, -2, -3), 1'b0, 0);
    add_dir(make_word(-32768, 0, 32767, 0, 32'sh7FFF_FFFF,
                      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0), 1'b0, 0);
    // half turns about x and y, quarter turns about each axis, mixed scales
    add_dir(make_word(16384, 0, 0, 0, 65536, 131072, -65536, 100, 200, 300),
            1'b0, 0);
    add_dir(make_word(0, 16384, 0, 0, -131072, 65536, 32768, 0, 0, 0), 1'b0, 0);
    add_dir(make_word(11585, 0, 0, 11585, 65536, 65536, 65536, 0, 0, 0), 1'b0, 0);
    add_dir(make_word(0, 11585, 0, -11585, 65536, 65536, 65536, 0, 0, 0), 1'b0, 0);
    add_dir(make_word(0, 0, 11585, 11585, 98304, -98304, 65536, 0, 0, 0), 1'b0, 0);
    // basis entries of one half against tiny odd scales: rounding ties
    // go away from zero in both signs
    add_dir(make_word(0, 8192, 0, 0, 1, -1, 3, 0, 0, 0), 1'b0, 0);
    add_dir(make_word(0, 8192, 0, 0, -3, 5, -5, 0, 0, 0), 1'b0, 0);
    add_dir(make_word(8192, 0, 8192, 0, -1, 1, 7, 0, 0, 0), 1'b0, 0);
    // general rotation, non-unit length
    add_dir(make_word(5000, -7000, 9000, 12000, 200000, -300000, 70000,
                      32'sh1234_5678, -32'sh0765_4321, 42), 1'b0, 0);

    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_word(dir_tab[i].word, dir_tab[i].rows, 1'b0);

    // random words, in blocks that are either gap-free or gappy
    gap_free = 1'b0;
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % 20 == 0)
        gap_free = ($urandom_range(0, 3) == 0);
      w.quat_x  = rand_quat_comp();
      w.quat_y  = rand_quat_comp();
      w.quat_z  = rand_quat_comp();
      w.quat_w  = rand_quat_comp();
      w.scale_x = rand_fix(1'b1);
      w.scale_y = rand_fix(1'b1);
      w.scale_z = rand_fix(1'b1);
      w.pos_x   = rand_fix(1'b0);
      w.pos_y   = rand_fix(1'b0);
      w.pos_z   = rand_fix(1'b0);
      send_word(w, compose_matrix(w), gap_free);
    end
    in_valid <= 1'b0;

    // drain, then give any stray row time to show up
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (mismatches == 0)
      $display("quat_trs_model_matrix test passed");
    else
      $display("quat_trs_model_matrix test failed");
    $finish;
  end

endmodule
